FILE: hdl/mstb_pkg.sv
// Shared types, codes and constants for the multi-slot software timer bank.
package mstb_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS   = 8;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 3;
    localparam int IVAL_W   = 16;
    localparam int MSG_W    = 32;
    localparam int TICK_W   = 11;
    localparam int ELAP_W   = 17;
    localparam int TOTAL_W  = 64;
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 2;
    localparam int NRES_W   = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 112;

    localparam logic [TICK_W-1:0] TICK_RESET = 11'd10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_CREATE_1 = 3'd2,
        OP_DESTROY  = 3'd3,
        OP_START    = 3'd4,
        OP_STOP     = 3'd5,
        OP_CHANGE   = 3'd6,
        OP_NONE     = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

endpackage

FILE: hdl/multi_slot_software_timer_bank.sv
// Top level of the multi-slot software timer bank: sequencer, slot stores and result stages.
// A tick walks every slot, one a cycle while the output does not stall it; a create walks for
// the lowest free slot; other commands pass through the command state, and a command refused
// at once (short interval, unused slot) goes straight to its status reply.
// Throughput: one item at a time, taken once the sequencer is back in idle; receiver stalls delay it.
// Reset (synchronous): slots free and stopped, counts and total zero, tick_ms 10; stores kept.
module multi_slot_software_timer_bank #(
    parameter int SLOTS = mstb_pkg::SLOTS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: tick_ms.
    input  logic                                i_cfg_wr_en,
    input  logic [mstb_pkg::TICK_W-1:0]         i_cfg_wr_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, lowest bit up: slot[2:0], interval_ms[18:3], message_type[50:19], zero fill.
    input  logic [mstb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: operation[2:0].
    input  logic [mstb_pkg::OP_W-1:0]           s_axis_tuser,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, lowest bit up: status[1:0], result_slot[4:2], expired_message[36:5],
    // total_elapsed_ms[100:37], created_count[104:101], running_count[108:105], zero fill.
    output logic [mstb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: kind.
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CMP_W = 6;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [SLOT_CMP_W-1:0] SLOTS_CMP = SLOT_CMP_W'(SLOTS);
    localparam logic [mstb_pkg::NRES_W-1:0] MAX_RES = mstb_pkg::NRES_W'(mstb_pkg::MAX_RESULTS);

    // The sequencer. Idle takes a transfer; the find state walks for the lowest free slot;
    // the command state applies destroy, start, stop or change to the addressed slot; the
    // scan state walks every slot for a tick; flush sends the final held expiry notice; and
    // emit sends a command's status reply.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_CMD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Input field views.
    logic [mstb_pkg::SLOT_W-1:0] in_slot;
    logic [mstb_pkg::IVAL_W-1:0] in_ival;
    logic [mstb_pkg::MSG_W-1:0]  in_msg;
    logic [SW-1:0]               in_slot_idx;
    logic                        in_accept;

    assign in_slot     = s_axis_tdata[2:0];
    assign in_ival     = s_axis_tdata[18:3];
    assign in_msg      = s_axis_tdata[50:19];
    assign in_slot_idx = SW'(in_slot);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    // Configuration and bank-wide state.
    logic [mstb_pkg::TICK_W-1:0]  r_tick_ms;
    logic [SLOTS-1:0]             r_in_use, n_in_use;
    logic [SLOTS-1:0]             r_running, n_running;
    logic [SLOTS-1:0]             r_one_shot, n_one_shot;
    logic [mstb_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [mstb_pkg::CNT_W-1:0]   r_in_use_cnt, n_in_use_cnt;
    logic [mstb_pkg::CNT_W-1:0]   r_run_cnt, n_run_cnt;

    // Per-slot stores; each is read at the sequencer index alone.
    logic [mstb_pkg::IVAL_W-1:0] r_period [SLOTS];
    logic [mstb_pkg::ELAP_W-1:0] r_elapsed [SLOTS];
    logic [mstb_pkg::MSG_W-1:0]  r_message [SLOTS];

    // Latched command and walk control.
    logic [mstb_pkg::OP_W-1:0]   r_op, n_op;
    logic [mstb_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [mstb_pkg::IVAL_W-1:0] r_ival, n_ival;
    logic [mstb_pkg::MSG_W-1:0]  r_msg, n_msg;
    logic [SW-1:0]               r_idx, n_idx;
    logic [mstb_pkg::NRES_W-1:0] r_nres, n_nres;

    // Status reply being built.
    logic [mstb_pkg::STATUS_W-1:0] r_rep_status, n_rep_status;
    logic [mstb_pkg::SLOT_W-1:0]   r_rep_slot, n_rep_slot;

    // Expiry notice held until it is known whether another one follows it.
    logic                          r_p_valid, n_p_valid;
    logic [mstb_pkg::SLOT_W-1:0]   r_p_slot, n_p_slot;
    logic [mstb_pkg::MSG_W-1:0]    r_p_msg, n_p_msg;
    logic [mstb_pkg::CNT_W-1:0]    r_p_cre, n_p_cre;
    logic [mstb_pkg::CNT_W-1:0]    r_p_run, n_p_run;

    // Output register.
    logic                          r_o_valid, n_o_valid;
    logic                          r_o_kind, n_o_kind;
    logic [mstb_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [mstb_pkg::SLOT_W-1:0]   r_o_slot, n_o_slot;
    logic [mstb_pkg::MSG_W-1:0]    r_o_msg, n_o_msg;
    logic [mstb_pkg::TOTAL_W-1:0]  r_o_total, n_o_total;
    logic [mstb_pkg::CNT_W-1:0]    r_o_cre, n_o_cre;
    logic [mstb_pkg::CNT_W-1:0]    r_o_run, n_o_run;
    logic                          r_o_last, n_o_last;

    // Slot store write port.
    logic                        wr_period_en, wr_elap_en, wr_msg_en;
    logic [mstb_pkg::IVAL_W-1:0] wr_period;
    logic [mstb_pkg::ELAP_W-1:0] wr_elap;

    // Shared elapsed-time unit: add one tick, compare with the period, take the period off.
    logic [mstb_pkg::ELAP_W-1:0] rd_elapsed, sum_elapsed, rem_elapsed;
    logic [mstb_pkg::ELAP_W-1:0] rd_period_ext;
    logic                        expire;

    assign rd_elapsed    = r_elapsed[r_idx];
    assign rd_period_ext = {1'b0, r_period[r_idx]};
    assign sum_elapsed   = rd_elapsed + {{(mstb_pkg::ELAP_W - mstb_pkg::TICK_W){1'b0}}, r_tick_ms};
    assign expire        = (sum_elapsed >= rd_period_ext);
    assign rem_elapsed   = sum_elapsed - rd_period_ext;

    logic out_free;
    assign out_free = !r_o_valid || m_axis_tready;

    logic scan_live, scan_report, scan_stall;
    assign scan_live   = r_in_use[r_idx] && r_running[r_idx];
    assign scan_report = scan_live && expire && (r_nres < MAX_RES);
    assign scan_stall  = scan_report && r_p_valid && !out_free;

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_running    = r_running;
        n_one_shot   = r_one_shot;
        n_total      = r_total;
        n_in_use_cnt = r_in_use_cnt;
        n_run_cnt    = r_run_cnt;
        n_op         = r_op;
        n_slot       = r_slot;
        n_ival       = r_ival;
        n_msg        = r_msg;
        n_idx        = r_idx;
        n_nres       = r_nres;
        n_rep_status = r_rep_status;
        n_rep_slot   = r_rep_slot;
        n_p_valid    = r_p_valid;
        n_p_slot     = r_p_slot;
        n_p_msg      = r_p_msg;
        n_p_cre      = r_p_cre;
        n_p_run      = r_p_run;
        n_o_valid    = r_o_valid && !m_axis_tready;
        n_o_kind     = r_o_kind;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_msg      = r_o_msg;
        n_o_total    = r_o_total;
        n_o_cre      = r_o_cre;
        n_o_run      = r_o_run;
        n_o_last     = r_o_last;
        wr_period_en = 1'b0;
        wr_elap_en   = 1'b0;
        wr_msg_en    = 1'b0;
        wr_period    = r_ival;
        wr_elap      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op   = s_axis_tuser;
                    n_slot = in_slot;
                    n_ival = in_ival;
                    n_msg  = in_msg;
                    n_idx  = '0;
                    unique case (mstb_pkg::t_op'(s_axis_tuser))
                        mstb_pkg::OP_TICK: begin
                            if (r_run_cnt != '0) begin
                                n_total   = r_total + {{(mstb_pkg::TOTAL_W
                                            - mstb_pkg::TICK_W){1'b0}}, r_tick_ms};
                                n_nres    = '0;
                                n_p_valid = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        mstb_pkg::OP_CREATE, mstb_pkg::OP_CREATE_1: begin
                            if (in_ival < {{(mstb_pkg::IVAL_W - mstb_pkg::TICK_W){1'b0}},
                                           r_tick_ms}) begin
                                n_rep_status = mstb_pkg::ST_SHORT;
                                n_rep_slot   = '0;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        mstb_pkg::OP_NONE: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            // Destroy, start, stop and change interval address a slot.
                            if ({3'b0, in_slot} >= SLOTS_CMP || !r_in_use[in_slot_idx]) begin
                                n_rep_status = mstb_pkg::ST_NOT_USED;
                                n_rep_slot   = in_slot;
                                n_state      = S_EMIT;
                            end else begin
                                n_idx   = in_slot_idx;
                                n_state = S_CMD;
                            end
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (!r_in_use[r_idx]) begin
                    n_in_use[r_idx]   = 1'b1;
                    n_one_shot[r_idx] = (r_op == mstb_pkg::OP_CREATE_1);
                    n_running[r_idx]  = (r_op == mstb_pkg::OP_CREATE_1);
                    n_in_use_cnt      = r_in_use_cnt + 1'b1;
                    if (r_op == mstb_pkg::OP_CREATE_1) begin
                        n_run_cnt = r_run_cnt + 1'b1;
                    end
                    wr_period_en = 1'b1;
                    wr_period    = r_ival;
                    wr_elap_en   = 1'b1;
                    wr_elap      = '0;
                    wr_msg_en    = 1'b1;
                    n_rep_status = mstb_pkg::ST_OK;
                    n_rep_slot   = 3'(r_idx);
                    n_state      = S_EMIT;
                end else if (r_idx == LAST_IDX) begin
                    n_rep_status = mstb_pkg::ST_NO_SLOT;
                    n_rep_slot   = '0;
                    n_state      = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_CMD: begin
                unique case (mstb_pkg::t_op'(r_op))
                    mstb_pkg::OP_DESTROY: begin
                        if (r_running[r_idx]) begin
                            n_run_cnt = r_run_cnt - 1'b1;
                        end
                        n_running[r_idx]  = 1'b0;
                        n_in_use[r_idx]   = 1'b0;
                        n_one_shot[r_idx] = 1'b0;
                        n_in_use_cnt      = r_in_use_cnt - 1'b1;
                    end
                    mstb_pkg::OP_START: begin
                        if (!r_running[r_idx]) begin
                            n_running[r_idx] = 1'b1;
                            n_run_cnt        = r_run_cnt + 1'b1;
                            wr_elap_en       = 1'b1;
                            wr_elap          = '0;
                        end
                    end
                    mstb_pkg::OP_STOP: begin
                        if (r_running[r_idx]) begin
                            n_running[r_idx] = 1'b0;
                            n_run_cnt        = r_run_cnt - 1'b1;
                        end
                    end
                    default: begin
                        wr_period_en = 1'b1;
                        wr_period    = r_ival;
                    end
                endcase
                n_rep_status = mstb_pkg::ST_OK;
                n_rep_slot   = r_slot;
                n_state      = S_EMIT;
            end

            S_SCAN: begin
                if (!scan_stall) begin
                    if (scan_live) begin
                        wr_elap_en = 1'b1;
                        wr_elap    = expire ? rem_elapsed : sum_elapsed;
                        if (expire && r_one_shot[r_idx]) begin
                            n_running[r_idx]  = 1'b0;
                            n_in_use[r_idx]   = 1'b0;
                            n_one_shot[r_idx] = 1'b0;
                            n_run_cnt         = r_run_cnt - 1'b1;
                            n_in_use_cnt      = r_in_use_cnt - 1'b1;
                        end
                    end
                    if (scan_report) begin
                        // A new notice means the held one is not the last of this tick.
                        if (r_p_valid) begin
                            n_o_valid  = 1'b1;
                            n_o_kind   = mstb_pkg::KIND_EXPIRY;
                            n_o_status = mstb_pkg::ST_OK;
                            n_o_slot   = r_p_slot;
                            n_o_msg    = r_p_msg;
                            n_o_total  = r_total;
                            n_o_cre    = r_p_cre;
                            n_o_run    = r_p_run;
                            n_o_last   = 1'b0;
                        end
                        n_p_valid = 1'b1;
                        n_p_slot  = 3'(r_idx);
                        n_p_msg   = r_message[r_idx];
                        n_p_cre   = n_in_use_cnt;
                        n_p_run   = n_run_cnt;
                        n_nres    = r_nres + 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_FLUSH: begin
                if (!r_p_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = mstb_pkg::KIND_EXPIRY;
                    n_o_status = mstb_pkg::ST_OK;
                    n_o_slot   = r_p_slot;
                    n_o_msg    = r_p_msg;
                    n_o_total  = r_total;
                    n_o_cre    = r_p_cre;
                    n_o_run    = r_p_run;
                    n_o_last   = 1'b1;
                    n_p_valid  = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = mstb_pkg::KIND_STATUS;
                    n_o_status = r_rep_status;
                    n_o_slot   = r_rep_slot;
                    n_o_msg    = '0;
                    n_o_total  = r_total;
                    n_o_cre    = r_in_use_cnt;
                    n_o_run    = r_run_cnt;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick_ms    <= mstb_pkg::TICK_RESET;
            r_in_use     <= '0;
            r_running    <= '0;
            r_one_shot   <= '0;
            r_total      <= '0;
            r_in_use_cnt <= '0;
            r_run_cnt    <= '0;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_tick_ms <= i_cfg_wr_data;
            end
            r_in_use     <= n_in_use;
            r_running    <= n_running;
            r_one_shot   <= n_one_shot;
            r_total      <= n_total;
            r_in_use_cnt <= n_in_use_cnt;
            r_run_cnt    <= n_run_cnt;
            r_p_valid    <= n_p_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_ival       <= n_ival;
        r_msg        <= n_msg;
        r_idx        <= n_idx;
        r_nres       <= n_nres;
        r_rep_status <= n_rep_status;
        r_rep_slot   <= n_rep_slot;
        r_p_slot     <= n_p_slot;
        r_p_msg      <= n_p_msg;
        r_p_cre      <= n_p_cre;
        r_p_run      <= n_p_run;
        r_o_kind     <= n_o_kind;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_msg      <= n_o_msg;
        r_o_total    <= n_o_total;
        r_o_cre      <= n_o_cre;
        r_o_run      <= n_o_run;
        r_o_last     <= n_o_last;
    end

    // Slot stores, written at the sequencer index.
    always_ff @(posedge i_clk) begin
        if (wr_period_en) begin
            r_period[r_idx] <= wr_period;
        end
        if (wr_elap_en) begin
            r_elapsed[r_idx] <= wr_elap;
        end
        if (wr_msg_en) begin
            r_message[r_idx] <= r_msg;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {3'b000, r_o_run, r_o_cre, r_o_total, r_o_msg, r_o_slot, r_o_status};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the multi-slot software timer bank.
module tb;
    import mstb_pkg::*;

    localparam int NSLOT        = SLOTS_DEFAULT;
    localparam int SETTLE_TICKS = NSLOT + 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int ITEM_TARGET  = 330;
    localparam int N_PHASES     = 4;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic          kind;
        t_status       status;
        logic [2:0]    slot;
        logic [31:0]   msg;
        logic [63:0]   total;
        logic [3:0]    created;
        logic [3:0]    running;
        logic          last;
    } timer_res_t;

    // One directed command; res is used only where typed is set.
    typedef struct packed {
        t_op           op;
        logic [2:0]    slot;
        logic [15:0]   ival;
        logic [31:0]   msg;
        logic          typed;
        timer_res_t    res;
    } dir_row_t;

    localparam timer_res_t NO_RES = '0;
    localparam int N_DIR = 27;

    // Runs with tick_ms at its reset value of 10 ms.
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // A tick with nothing running and operation 7 are both dropped silently.
        '{OP_TICK,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_NONE,     3'd5, 16'hFFFF,  32'hFFFF_FFFF,  1'b0, NO_RES},
        '{OP_DESTROY,  3'd7, 16'd0,     32'd0,          1'b1,
          '{KIND_STATUS, ST_NOT_USED, 3'd7, 32'd0, 64'd0, 4'd0, 4'd0, 1'b1}},
        // Interval one below the tick is refused.
        '{OP_CREATE,   3'd0, 16'd9,     32'd1,          1'b1,
          '{KIND_STATUS, ST_SHORT, 3'd0, 32'd0, 64'd0, 4'd0, 4'd0, 1'b1}},
        '{OP_CREATE,   3'd0, 16'd10,    32'hFFFF_FFFF,  1'b1,
          '{KIND_STATUS, ST_OK, 3'd0, 32'd0, 64'd0, 4'd1, 4'd0, 1'b1}},
        '{OP_CREATE_1, 3'd0, 16'hFFFF,  32'd0,          1'b1,
          '{KIND_STATUS, ST_OK, 3'd1, 32'd0, 64'd0, 4'd2, 4'd1, 1'b1}},
        '{OP_START,    3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_START,    3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_TICK,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        // A zero period expires on every tick; the one-shot slot frees itself.
        '{OP_CHANGE,   3'd1, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_TICK,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_STOP,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_STOP,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_TICK,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_CHANGE,   3'd5, 16'd100,   32'd0,          1'b1,
          '{KIND_STATUS, ST_NOT_USED, 3'd5, 32'd0, 64'd20, 4'd1, 4'd0, 1'b1}},
        // Fill the bank with one-shot timers that all expire on the next tick.
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0001,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0002,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0003,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0004,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0005,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'hA5A5_0006,  1'b0, NO_RES},
        '{OP_CREATE_1, 3'd0, 16'd10,    32'h5A5A_FFFF,  1'b0, NO_RES},
        '{OP_CREATE,   3'd0, 16'd100,   32'd7,          1'b1,
          '{KIND_STATUS, ST_NO_SLOT, 3'd0, 32'd0, 64'd20, 4'd8, 4'd7, 1'b1}},
        '{OP_START,    3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        // Eight expiry notices from a single tick.
        '{OP_TICK,     3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_DESTROY,  3'd0, 16'd0,     32'd0,          1'b0, NO_RES},
        '{OP_DESTROY,  3'd0, 16'd0,     32'd0,          1'b1,
          '{KIND_STATUS, ST_NOT_USED, 3'd0, 32'd0, 64'd30, 4'd0, 4'd0, 1'b1}}
    };

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_wr_en    = 1'b0;
    logic [TICK_W-1:0]       i_cfg_wr_data  = '0;
    logic                    s_axis_tvalid  = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata   = '0;
    logic [OP_W-1:0]         s_axis_tuser   = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    // Shadow copy of the timer bank, kept in step with accepted commands.
    logic [TICK_W-1:0]       bank_tick_ms            = TICK_RESET;
    logic                    bank_in_use   [NSLOT]   = '{default: 1'b0};
    logic                    bank_running  [NSLOT]   = '{default: 1'b0};
    logic                    bank_one_shot [NSLOT]   = '{default: 1'b0};
    logic [IVAL_W-1:0]       bank_period   [NSLOT]   = '{default: '0};
    logic [ELAP_W-1:0]       bank_elapsed  [NSLOT]   = '{default: '0};
    logic [MSG_W-1:0]        bank_message  [NSLOT]   = '{default: '0};
    logic [TOTAL_W-1:0]      bank_total              = '0;
    logic [CNT_W-1:0]        bank_used               = '0;
    logic [CNT_W-1:0]        bank_run                = '0;

    timer_res_t              pending_results [$];
    timer_res_t              step_results [$];
    int                      fail_count   = 0;
    int                      burst_left   = 0;
    int                      sent_items   = 0;
    int                      quiet_cycles = 0;
    logic [7:0]              ready_phase  = '0;

    multi_slot_software_timer_bank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- shadow model

    function automatic timer_res_t bank_result(input logic kind, input t_status st,
                                               input logic [2:0] slot, input logic [31:0] msg);
        timer_res_t r;
        r.kind    = kind;
        r.status  = st;
        r.slot    = slot;
        r.msg     = msg;
        r.total   = bank_total;
        r.created = bank_used;
        r.running = bank_run;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic void halt_timer(input int s);
        if (bank_running[s]) begin
            bank_running[s] = 1'b0;
            bank_run        = bank_run - 1'b1;
        end
    endfunction

    function automatic void free_timer(input int s);
        halt_timer(s);
        bank_in_use[s]   = 1'b0;
        bank_one_shot[s] = 1'b0;
        bank_used        = bank_used - 1'b1;
    endfunction

    // Applies one command to the shadow bank and leaves its results in step_results.
    task automatic predict_bank_step(input t_op op, input logic [2:0] slot,
                                     input logic [15:0] ival, input logic [31:0] msg);
        int         found;
        timer_res_t tail;
        step_results.delete();
        case (op)
            OP_TICK: begin
                if (bank_run != '0) begin
                    bank_total = bank_total + TOTAL_W'(bank_tick_ms);
                    for (int i = 0; i < NSLOT; i++) begin
                        if (bank_in_use[i] && bank_running[i]) begin
                            bank_elapsed[i] = bank_elapsed[i] + ELAP_W'(bank_tick_ms);
                            if (bank_elapsed[i] >= ELAP_W'(bank_period[i])) begin
                                bank_elapsed[i] = bank_elapsed[i] - ELAP_W'(bank_period[i]);
                                // Counts in the notice already reflect a freed one-shot.
                                if (bank_one_shot[i])
                                    free_timer(i);
                                if (step_results.size() < MAX_RESULTS)
                                    step_results.push_back(bank_result(KIND_EXPIRY, ST_OK,
                                                                       3'(i), bank_message[i]));
                            end
                        end
                    end
                end
            end
            OP_CREATE, OP_CREATE_1: begin
                found = NSLOT;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!bank_in_use[i])
                        found = i;
                if (ival < IVAL_W'(bank_tick_ms)) begin
                    step_results.push_back(bank_result(KIND_STATUS, ST_SHORT, 3'd0, 32'd0));
                end else if (found == NSLOT) begin
                    step_results.push_back(bank_result(KIND_STATUS, ST_NO_SLOT, 3'd0, 32'd0));
                end else begin
                    bank_in_use[found]   = 1'b1;
                    bank_period[found]   = ival;
                    bank_elapsed[found]  = '0;
                    bank_message[found]  = msg;
                    bank_one_shot[found] = (op == OP_CREATE_1);
                    bank_running[found]  = (op == OP_CREATE_1);
                    bank_used            = bank_used + 1'b1;
                    if (op == OP_CREATE_1)
                        bank_run = bank_run + 1'b1;
                    step_results.push_back(bank_result(KIND_STATUS, ST_OK, 3'(found), 32'd0));
                end
            end
            OP_NONE: begin
            end
            default: begin
                if (!bank_in_use[slot]) begin
                    step_results.push_back(bank_result(KIND_STATUS, ST_NOT_USED, slot, 32'd0));
                end else begin
                    case (op)
                        OP_DESTROY: free_timer(slot);
                        OP_START: begin
                            // Starting a running timer leaves its elapsed time alone.
                            if (!bank_running[slot]) begin
                                bank_running[slot] = 1'b1;
                                bank_elapsed[slot] = '0;
                                bank_run           = bank_run + 1'b1;
                            end
                        end
                        OP_STOP: halt_timer(slot);
                        default: bank_period[slot] = ival;
                    endcase
                    step_results.push_back(bank_result(KIND_STATUS, ST_OK, slot, 32'd0));
                end
            end
        endcase
        if (step_results.size() > 0) begin
            tail      = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    // Sends one command in bursts with random gaps, then records what it must produce.
    task automatic issue_item(input t_op op, input logic [2:0] slot, input logic [15:0] ival,
                              input logic [31:0] msg, input logic typed, input timer_res_t res);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, msg, ival, slot};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        burst_left--;
        sent_items++;
        predict_bank_step(op, slot, ival, msg);
        if (typed)
            pending_results.push_back(res);
        else
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
    endtask

    // Mostly periods a few ticks long so that timers expire often.
    task automatic random_item();
        int          pick;
        int          hi;
        t_op         op;
        logic [15:0] ival;
        pick = $urandom_range(0, 99);
        if (pick < 38)      op = OP_TICK;
        else if (pick < 50) op = OP_CREATE;
        else if (pick < 60) op = OP_CREATE_1;
        else if (pick < 68) op = OP_DESTROY;
        else if (pick < 78) op = OP_START;
        else if (pick < 86) op = OP_STOP;
        else if (pick < 96) op = OP_CHANGE;
        else                op = OP_NONE;
        hi = int'(bank_tick_ms) * 6;
        if (hi > 65535)
            hi = 65535;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ival = 16'($urandom_range(0, int'(bank_tick_ms) - 1));
        else if (pick < 80)
            ival = 16'($urandom_range(int'(bank_tick_ms), hi));
        else
            ival = 16'($urandom_range(0, 65535));
        issue_item(op, 3'($urandom_range(0, 7)), ival, $urandom(), 1'b0, NO_RES);
    endtask

    // Holds the sender back until every expected result is in and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_tick_ms(input logic [TICK_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        bank_tick_ms = val;
    endtask

    initial begin
        int tick_plan [N_PHASES];
        int target;
        tick_plan = '{1, 2000, $urandom_range(2, 1999), 10};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_DIR; r++)
            issue_item(DIR_ROWS[r].op, DIR_ROWS[r].slot, DIR_ROWS[r].ival, DIR_ROWS[r].msg,
                       DIR_ROWS[r].typed, DIR_ROWS[r].res);
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            set_tick_ms(TICK_W'(tick_plan[p]));
            target = ITEM_TARGET * (p + 1) / N_PHASES;
            while (sent_items < target) begin
                random_item();
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
            end
        end
        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // The receiver stalls on a fixed pattern, with long stretches of no stall at all.
    always @(posedge i_clk) begin
        ready_phase   <= ready_phase + 8'd1;
        m_axis_tready <= ready_phase[7] ||
                         !((ready_phase % 5 == 2) || (ready_phase[4:3] == 2'b11));
    end

    task automatic report_mismatch(input string line);
        fail_count++;
        $display("[%0t] MISMATCH %s", $realtime, line);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        timer_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("kind",    m_axis_tuser,           want.kind);
                check_field("status",  m_axis_tdata[1:0],      want.status);
                check_field("slot",    m_axis_tdata[4:2],      want.slot);
                check_field("message", m_axis_tdata[36:5],     want.msg);
                check_field("total",   m_axis_tdata[100:37],   want.total);
                check_field("created", m_axis_tdata[104:101],  want.created);
                check_field("running", m_axis_tdata[108:105],  want.running);
                check_field("last",    m_axis_tlast,           want.last);
            end
        end
    end

    // Ends a hung run: too many cycles in a row without a transfer on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
